// ===== rtl/tcfb_pkg.sv =====
// Shared types, constants and helper functions for the tactile contact force binner.
// No dependencies; imported by the top level, tcfb_mul and tcfb_chk.
package tcfb_pkg;

  localparam int NUM_SENSORS  = 16;
  localparam int LINK_ID_BITS = 8;

  localparam int SW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int CW = $clog2(NUM_SENSORS + 1);
  localparam int MW = 33;
  localparam int PW = 2 * MW;
  localparam int POS_W = 3 * 32 + 32 + LINK_ID_BITS;
  localparam int ROT_W = 3 * 16;
  localparam int ACC_W = 3 * 32;

  typedef enum logic [1:0] {
    CMD_LOAD_POS = 2'd0,
    CMD_LOAD_ROT = 2'd1,
    CMD_CONTACT  = 2'd2,
    CMD_FRAME    = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_SENSOR_COUNT = 1'b0,
    CFG_COS_LIMIT    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         slot;
    logic [7:0]         link_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } in_t;

  typedef struct packed {
    logic [3:0]         sensor_index;
    logic signed [31:0] sensed_x;
    logic signed [31:0] sensed_y;
    logic signed [31:0] sensed_z;
    logic               last;
  } out_t;

  function automatic logic [5:0] div3(input logic [5:0] v);
    logic [12:0] p;
    p = 13'(v) * 13'd43;
    return p[12:7];
  endfunction

  function automatic logic [3:0] split3(input logic [3:0] c);
    logic [3:0] r;
    case (c)
      4'd0:    r = {2'd0, 2'd0};
      4'd1:    r = {2'd0, 2'd1};
      4'd2:    r = {2'd0, 2'd2};
      4'd3:    r = {2'd1, 2'd0};
      4'd4:    r = {2'd1, 2'd1};
      4'd5:    r = {2'd1, 2'd2};
      4'd6:    r = {2'd2, 2'd0};
      4'd7:    r = {2'd2, 2'd1};
      4'd8:    r = {2'd2, 2'd2};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/tactile_contact_force_binning_top.sv =====
// Top level of the tactile contact force binner: sequencer, sensor table and accumulators.
// Depends on tcfb_pkg, tcfb_ram and tcfb_mul.
//
// Sensor loads (position and rotation rows) are written from idle. A contact scans
// the sensors in order (fetch, difference, multiply, decide) up to the first match,
// then rotates and accumulates the force on a match; every product goes through one shared
// 33x33 multiplier, so the scan is bound by its seven products per sensor and
// nine products per accumulate. End of frame emits one report per sensor in use,
// holding on output back-pressure, and then clears all accumulators.
module tactile_contact_force_binning_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tcfb_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tcfb_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [15:0]     cfg_data_i
);
  import tcfb_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_FETCH  = 9'b000000010,
    ST_DIFF   = 9'b000000100,
    ST_MUL    = 9'b000001000,
    ST_DECIDE = 9'b000010000,
    ST_FORCE  = 9'b000100000,
    ST_WRITE  = 9'b001000000,
    ST_ERD    = 9'b010000000,
    ST_EOUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [SW-1:0] s_q, s_d;
  logic [4:0]    count_q;
  logic signed [15:0] lim_q;
  logic [NUM_SENSORS-1:0] valid_q;
  logic          out_valid_q;
  out_t          out_q;

  in_t ctx_q;
  logic signed [32:0] diff_q [3];
  logic [65:0]        d2_q;
  logic [63:0]        rr_q;
  logic signed [33:0] dot_q;
  logic signed [49:0] t_q;
  logic [31:0]        nacc_q [3];

  logic accept, pos_we, acc_we, out_load, last_s, match, clear_all;
  logic [5:0] slot_div, slot_rem;
  logic [2:0] rot_we;
  logic [CW-1:0] n_used;
  logic [POS_W-1:0] pos_rd;
  logic [ROT_W-1:0] rot_rd [3];
  logic [ACC_W-1:0] acc_rd, acc_old;
  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;
  logic [3:0] pc, fjk, pjk;
  logic signed [31:0] s_pos [3];
  logic signed [31:0] s_rad;
  logic [LINK_ID_BITS-1:0] s_link;
  logic signed [15:0] c_nrm [3];
  logic signed [31:0] c_frc [3];
  logic signed [33:0] dot_c, lim_ext;
  logic signed [49:0] t_fin, t_rnd;
  logic signed [36:0] acc_sum;
  logic [31:0] acc_sat;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    if (int'(count_q) > NUM_SENSORS) begin
      n_used = CW'(NUM_SENSORS);
    end else begin
      n_used = CW'(count_q);
    end
  end

  assign last_s = ((CW'(s_q) + CW'(1)) == n_used);

  assign slot_div = div3(in_data_i.slot);
  assign slot_rem = in_data_i.slot - 6'(8'(slot_div) * 8'd3);

  assign pos_we = accept && (in_data_i.cmd == CMD_LOAD_POS) &&
                  (int'(in_data_i.slot) < NUM_SENSORS);

  for (genvar r = 0; r < 3; r++) begin : g_rot
    assign rot_we[r] = accept && (in_data_i.cmd == CMD_LOAD_ROT) &&
                       (int'(in_data_i.slot) < 3 * NUM_SENSORS) &&
                       (slot_rem[1:0] == 2'(r));
    tcfb_ram #(.Width(ROT_W), .Depth(NUM_SENSORS)) u_rot (
      .clk_i   (clk_i),
      .we_i    (rot_we[r]),
      .waddr_i (SW'(slot_div)),
      .wdata_i ({in_data_i.pos_z[15:0], in_data_i.pos_y[15:0], in_data_i.pos_x[15:0]}),
      .raddr_i (s_q),
      .rdata_o (rot_rd[r])
    );
  end

  tcfb_ram #(.Width(POS_W), .Depth(NUM_SENSORS)) u_pos (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (SW'(in_data_i.slot)),
    .wdata_i ({in_data_i.link_id[LINK_ID_BITS-1:0], in_data_i.force_x,
               in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x}),
    .raddr_i (s_q),
    .rdata_o (pos_rd)
  );

  assign acc_we = (state_q == ST_WRITE);

  tcfb_ram #(.Width(ACC_W), .Depth(NUM_SENSORS)) u_acc (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (s_q),
    .wdata_i ({nacc_q[2], nacc_q[1], nacc_q[0]}),
    .raddr_i (s_q),
    .rdata_o (acc_rd)
  );

  assign acc_old = valid_q[s_q] ? acc_rd : '0;

  assign s_pos[0] = pos_rd[31:0];
  assign s_pos[1] = pos_rd[63:32];
  assign s_pos[2] = pos_rd[95:64];
  assign s_rad    = pos_rd[127:96];
  assign s_link   = pos_rd[128 +: LINK_ID_BITS];

  assign c_nrm[0] = ctx_q.normal_x;
  assign c_nrm[1] = ctx_q.normal_y;
  assign c_nrm[2] = ctx_q.normal_z;
  assign c_frc[0] = ctx_q.force_x;
  assign c_frc[1] = ctx_q.force_y;
  assign c_frc[2] = ctx_q.force_z;

  assign pc  = cnt_q - 4'd1;
  assign fjk = split3(cnt_q);
  assign pjk = split3(pc);

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_q == ST_MUL) begin
      case (cnt_q)
        4'd0, 4'd1, 4'd2: begin
          op_a = diff_q[cnt_q[1:0]];
          op_b = diff_q[cnt_q[1:0]];
        end
        4'd3: begin
          op_a = MW'(s_rad);
          op_b = MW'(s_rad);
        end
        4'd4, 4'd5, 4'd6: begin
          op_a = MW'(c_nrm[2'(cnt_q - 4'd4)]);
          op_b = MW'($signed(rot_rd[2'(cnt_q - 4'd4)][47:32]));
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end else if ((state_q == ST_FORCE) && (cnt_q < 4'd9)) begin
      op_a = MW'($signed(rot_rd[fjk[1:0]][16 * fjk[3:2] +: 16]));
      op_b = MW'(c_frc[fjk[1:0]]);
    end
  end

  tcfb_mul u_mul (
    .clk_i (clk_i),
    .a_i   (op_a),
    .b_i   (op_b),
    .p_o   (prod)
  );

  assign lim_ext = {{4{lim_q[15]}}, lim_q, 14'b0};

  always_comb begin
    if (dot_q > 34'sd268435456) begin
      dot_c = 34'sd268435456;
    end else if (dot_q < -34'sd268435456) begin
      dot_c = -34'sd268435456;
    end else begin
      dot_c = dot_q;
    end
  end

  assign match = (s_link != '1) && (s_link == ctx_q.link_id[LINK_ID_BITS-1:0]) &&
                 !s_rad[31] && (d2_q <= {2'b00, rr_q}) && (dot_c >= lim_ext);

  assign t_fin   = t_q + 50'(prod);
  assign t_rnd   = (t_fin + 50'sd8192) >>> 14;
  assign acc_sum = 37'($signed(acc_old[32 * pjk[3:2] +: 32])) + 37'(t_rnd);

  always_comb begin
    if (acc_sum > 37'sd2147483647) begin
      acc_sat = 32'h7fffffff;
    end else if (acc_sum < -37'sd2147483648) begin
      acc_sat = 32'h80000000;
    end else begin
      acc_sat = acc_sum[31:0];
    end
  end

  assign out_load = (state_q == ST_EOUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    s_d       = s_q;
    clear_all = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.cmd == CMD_CONTACT)) begin
          s_d = '0;
          if (n_used != '0) begin
            state_d = ST_FETCH;
          end
        end else if (accept && (in_data_i.cmd == CMD_FRAME)) begin
          s_d = '0;
          if (n_used != '0) begin
            state_d = ST_ERD;
          end else begin
            clear_all = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cnt_d = '0;
        if (match) begin
          state_d = ST_FORCE;
        end else if (last_s) begin
          state_d = ST_IDLE;
        end else begin
          s_d     = s_q + SW'(1);
          state_d = ST_FETCH;
        end
      end
      ST_FORCE: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd9) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      ST_ERD: begin
        state_d = ST_EOUT;
      end
      ST_EOUT: begin
        if (out_load) begin
          if (last_s) begin
            clear_all = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            s_d     = s_q + SW'(1);
            state_d = ST_ERD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      s_q         <= '0;
      count_q     <= '0;
      lim_q       <= 16'sd16384;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      s_q     <= s_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SENSOR_COUNT: count_q <= cfg_data_i[4:0];
          CFG_COS_LIMIT:    lim_q   <= $signed(cfg_data_i);
          default:          count_q <= count_q;
        endcase
      end
      if (clear_all) begin
        valid_q <= '0;
      end else if (acc_we) begin
        valid_q[s_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctx_q <= in_data_i;
    end
    if (state_q == ST_DIFF) begin
      for (int k = 0; k < 3; k++) begin
        diff_q[k] <= 33'(s_pos[k]) - 33'(c_frc[k] - c_frc[k] + ((k == 0) ? ctx_q.pos_x :
                     (k == 1) ? ctx_q.pos_y : ctx_q.pos_z));
      end
    end
    if ((state_q == ST_MUL) && (cnt_q != 4'd0)) begin
      case (pc)
        4'd0:       d2_q  <= prod[65:0];
        4'd1, 4'd2: d2_q  <= d2_q + prod[65:0];
        4'd3:       rr_q  <= prod[63:0];
        4'd4:       dot_q <= 34'(prod);
        4'd5, 4'd6: dot_q <= dot_q + 34'(prod);
        default:    dot_q <= dot_q;
      endcase
    end
    if ((state_q == ST_FORCE) && (cnt_q != 4'd0)) begin
      case (pjk[1:0])
        2'd0:    t_q <= 50'(prod);
        2'd1:    t_q <= t_fin;
        default: nacc_q[pjk[3:2]] <= acc_sat;
      endcase
    end
    if (out_load) begin
      out_q.sensor_index <= 4'(s_q);
      out_q.sensed_x     <= acc_old[31:0];
      out_q.sensed_y     <= acc_old[63:32];
      out_q.sensed_z     <= acc_old[95:64];
      out_q.last         <= last_s;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/tcfb_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module tcfb_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/tcfb_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on tcfb_pkg.
module tcfb_mul (
  input  logic                            clk_i,
  input  logic signed [tcfb_pkg::MW-1:0]  a_i,
  input  logic signed [tcfb_pkg::MW-1:0]  b_i,
  output logic signed [tcfb_pkg::PW-1:0]  p_o
);
  import tcfb_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= PW'(a_i) * PW'(b_i);
  end

endmodule

// ===== rtl/tcfb_chk.sv =====
// Port-level checker for the tactile contact force binner, bound to the top level.
// Depends on tcfb_pkg and tactile_contact_force_binning_top.
module tcfb_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input tcfb_pkg::in_t   in_data_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input tcfb_pkg::out_t  out_data_o
);
  import tcfb_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.cmd == CMD_LOAD_POS || in_data_i.cmd == CMD_LOAD_ROT)
    |=> in_ready_o)
    else $error("table load did not complete in one cycle");

  a_contact_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.cmd == CMD_CONTACT) && !out_valid_o |=> !out_valid_o)
    else $error("contact produced a report");

  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input taken in the middle of a frame report");

endmodule

bind tactile_contact_force_binning_top tcfb_chk u_tcfb_chk (.*);
